>>> rtl/aes_pkg.sv
// Shared types, constants and round functions for the AES block.
`default_nettype none
package aes_pkg;

  localparam int NUM_WORDS  = 60;  // round key words for the largest key size
  localparam int NUM_CELLS  = 14;  // round cells after the initial key stage
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_3    = 3'd4;

  localparam logic [1:0] KS_128 = 2'd0;
  localparam logic [1:0] KS_192 = 2'd1;

  localparam logic OP_ENC = 1'b0;

  typedef struct packed {
    logic        operation;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_t;

  typedef struct packed {
    logic valid;
    logic op;
  } cell_ctl_t;

  localparam logic [0:255][7:0] SBOX = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

  localparam logic [0:255][7:0] INV_SBOX = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte n of the state sits at bits [127-8n -: 8]
  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    o = '0;
    for (int n = 0; n < 16; n++) begin
      o[127-8*n -: 8] = inv ? INV_SBOX[s[127-8*n -: 8]] : SBOX[s[127-8*n -: 8]];
    end
    return o;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    int src;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? 4 * ((c - r) & 3) + r : 4 * ((c + r) & 3) + r;
        o[127-8*(4*c+r) -: 8] = s[127-8*src -: 8];
      end
    end
    return o;
  endfunction

  // constant multiply; k is the coefficient slot of the mixing row
  function automatic logic [7:0] cmul(input logic [7:0] a, input logic [1:0] k,
                                      input logic inv);
    logic [7:0] a2, a4, a8, v;
    a2 = xtime(a);
    a4 = xtime(a2);
    a8 = xtime(a4);
    v  = a;
    unique case ({inv, k})
      3'b000:  v = a2;
      3'b001:  v = a2 ^ a;
      3'b010:  v = a;
      3'b011:  v = a;
      3'b100:  v = a8 ^ a4 ^ a2;
      3'b101:  v = a8 ^ a2 ^ a;
      3'b110:  v = a8 ^ a4 ^ a;
      3'b111:  v = a8 ^ a;
      default: v = a;
    endcase
    return v;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    logic [7:0]   v;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        v = '0;
        for (int k = 0; k < 4; k++) begin
          v ^= cmul(s[127-8*(4*c+k) -: 8], 2'((k - r) & 3), inv);
        end
        o[127-8*(4*c+r) -: 8] = v;
      end
    end
    return o;
  endfunction

endpackage
`default_nettype wire

>>> rtl/aes_keyexp.sv
// Key expansion sequencer: one schedule word per cycle into the round key store.
`default_nettype none
module aes_keyexp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                restart,
  input  wire logic [1:0]                          key_size,
  input  wire logic [255:0]                        key,
  output logic                                     busy,
  output logic [aes_pkg::NUM_WORDS-1:0][31:0]      rk
);
  import aes_pkg::*;

  typedef enum logic [2:0] {
    KX_IDLE = 3'b001,
    KX_LOAD = 3'b010,
    KX_RUN  = 3'b100
  } kx_state_t;

  kx_state_t   state;
  logic [5:0]  idx;
  logic [2:0]  cnt;
  logic [7:0]  rc;
  logic [7:0][31:0] win;   // win[7] is the newest word

  logic [2:0]  nk_m1;
  logic [3:0]  nk;
  logic [5:0]  last_idx;
  logic [31:0] prev, far, rot, t, new_word;
  logic [7:0][31:0] kw;

  always_comb begin
    for (int n = 0; n < 8; n++) begin
      kw[n] = key[255-32*n -: 32];
    end
    if (key_size == KS_128) begin
      nk_m1 = 3'd3; last_idx = 6'd43; far = win[4];
    end else if (key_size == KS_192) begin
      nk_m1 = 3'd5; last_idx = 6'd51; far = win[2];
    end else begin
      nk_m1 = 3'd7; last_idx = 6'd59; far = win[0];
    end
    nk   = {1'b0, nk_m1} + 4'd1;
    prev = win[7];
    rot  = {prev[23:0], prev[31:24]};
    if (cnt == 3'd0) begin
      t = sub_word(rot) ^ {rc, 24'h0};
    end else if (nk_m1 == 3'd7 && cnt == 3'd4) begin
      t = sub_word(prev);
    end else begin
      t = prev;
    end
    new_word = far ^ t;
  end

  assign busy = (state != KX_IDLE);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= KX_LOAD;
    end else begin
      unique case (state)
        KX_IDLE: state <= KX_IDLE;
        KX_LOAD: state <= KX_RUN;
        KX_RUN:  if (idx == last_idx) state <= KX_IDLE;
        default: state <= KX_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == KX_LOAD) begin
      for (int n = 0; n < 8; n++) begin
        rk[n] <= kw[n];
      end
      if (key_size == KS_128) begin
        win <= {kw[3], kw[2], kw[1], kw[0], 128'h0};
      end else if (key_size == KS_192) begin
        win <= {kw[5], kw[4], kw[3], kw[2], kw[1], kw[0], 64'h0};
      end else begin
        win <= kw;
      end
      idx <= {2'b00, nk};
      cnt <= 3'd0;
      rc  <= 8'h01;
    end else if (state == KX_RUN) begin
      rk[idx] <= new_word;
      win     <= {new_word, win[7:1]};
      idx     <= idx + 6'd1;
      cnt     <= (cnt == nk_m1) ? 3'd0 : cnt + 3'd1;
      if (cnt == 3'd0) rc <= xtime(rc);
    end
  end

endmodule
`default_nettype wire

>>> rtl/aes_round.sv
// One round cell of the cipher chain, registered output.
`default_nettype none
module aes_round (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire aes_pkg::cell_ctl_t    ctl_in,
  input  wire logic [127:0]          state_in,
  input  wire logic                  last,
  input  wire logic [127:0]          key_enc,
  input  wire logic [127:0]          key_dec,
  output aes_pkg::cell_ctl_t         ctl_out,
  output logic [127:0]               state_out
);
  import aes_pkg::*;

  logic [127:0] e_t, e_m, d_u, d_m, state_next;

  always_comb begin
    e_t = shift_rows(sub_bytes(state_in, 1'b0), 1'b0);
    e_m = mix_columns(e_t, 1'b0);
    d_u = sub_bytes(shift_rows(state_in, 1'b1), 1'b1) ^ key_dec;
    d_m = mix_columns(d_u, 1'b1);
    if (ctl_in.op == OP_ENC) begin
      state_next = (last ? e_t : e_m) ^ key_enc;
    end else begin
      state_next = last ? d_u : d_m;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
    state_out <= state_next;
  end

endmodule
`default_nettype wire

>>> rtl/aes_block_cipher.sv
// Top level: AES-128/192/256 cipher as a chain of round cells.
// Each item passes the key stage and then one round cell per round for 128, 192
// or 256 bit keys. Throughput: one item per clock while busy is low.
// After reset or any register write, busy stays high while the key schedule
// is built one word a cycle. Reset clears the key registers, the size select
// and every valid bit; the receiver cannot stall.
`default_nettype none
module aes_block_cipher (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire aes_pkg::in_t                      block,
  output logic                                   done,
  output aes_pkg::out_t                          result,
  input  wire logic                              cfg_we,
  input  wire logic [aes_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [aes_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import aes_pkg::*;

  // configuration registers
  logic [1:0]       key_size;
  logic [3:0][63:0] key_reg;   // key_reg[3] holds key bytes 0..7

  always_ff @(posedge clk) begin
    if (rst) begin
      key_size <= KS_128;
      key_reg  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_SIZE: key_size   <= cfg_data[1:0];
        REG_KEY_0:    key_reg[3] <= cfg_data;
        REG_KEY_1:    key_reg[2] <= cfg_data;
        REG_KEY_2:    key_reg[1] <= cfg_data;
        REG_KEY_3:    key_reg[0] <= cfg_data;
        default:      ;  // unknown index: write dropped
      endcase
    end
  end

  // key schedule, rebuilt whenever a register is written
  logic [NUM_WORDS-1:0][31:0] rk;

  aes_keyexp u_keyexp (
    .clk      (clk),
    .rst      (rst),
    .restart  (cfg_we),
    .key_size (key_size),
    .key      (key_reg),
    .busy     (busy),
    .rk       (rk)
  );

  function automatic logic [127:0] round_key(input logic [NUM_WORDS-1:0][31:0] w,
                                             input int r);
    return {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  logic [3:0] nr;
  always_comb begin
    if (key_size == KS_128)      nr = 4'd10;
    else if (key_size == KS_192) nr = 4'd12;
    else                         nr = 4'd14;  // code three runs as 256
  end

  // chain: stage 0 is the first key add, stages 1..14 the round cells
  cell_ctl_t           ctl [NUM_CELLS+1];
  logic [127:0]        st  [NUM_CELLS+1];
  logic [127:0]        key_first;

  always_comb begin
    if (block.operation == OP_ENC)  key_first = round_key(rk, 0);
    else if (key_size == KS_128)    key_first = round_key(rk, 10);
    else if (key_size == KS_192)    key_first = round_key(rk, 12);
    else                            key_first = round_key(rk, 14);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else begin
      ctl[0].valid <= start && !busy;
      ctl[0].op    <= block.operation;
    end
    st[0] <= {block.block_high, block.block_low} ^ key_first;
  end

  for (genvar j = 1; j <= NUM_CELLS; j++) begin : g_cell
    // decrypt round keys run downwards from the last round
    localparam int D10 = (j <= 10) ? 10 - j : 0;
    localparam int D12 = (j <= 12) ? 12 - j : 0;
    localparam int D14 = 14 - j;

    logic [127:0] key_dec;
    logic         last;

    always_comb begin
      if (key_size == KS_128)      key_dec = round_key(rk, D10);
      else if (key_size == KS_192) key_dec = round_key(rk, D12);
      else                         key_dec = round_key(rk, D14);
    end
    assign last = (nr == 4'(j));

    aes_round u_round (
      .clk       (clk),
      .rst       (rst),
      .ctl_in    (ctl[j-1]),
      .state_in  (st[j-1]),
      .last      (last),
      .key_enc   (round_key(rk, j)),
      .key_dec   (key_dec),
      .ctl_out   (ctl[j]),
      .state_out (st[j])
    );
  end

  // result tap sits at the cell of the final round
  logic [127:0] res;
  always_comb begin
    if (key_size == KS_128) begin
      done = ctl[10].valid; res = st[10];
    end else if (key_size == KS_192) begin
      done = ctl[12].valid; res = st[12];
    end else begin
      done = ctl[14].valid; res = st[14];
    end
    result.result_high = res[127:64];
    result.result_low  = res[63:0];
  end

endmodule
`default_nettype wire

>>> rtl/aes_chk.sv
// Port-level checker for the AES block, bound to the top level.
`default_nettype none
module aes_chk (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic cfg_we
);

  // a register write always rebuilds the key schedule
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst) cfg_we |=> busy)
    else $error("busy low after a configuration write");

  // out of reset: schedule being built, nothing in flight
  a_rst: assert property (@(posedge clk) rst |=> (busy && !done))
    else $error("busy low or result shown after reset");

  // every result traces back to an item taken one of the three latencies ago
  a_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy, 11) || $past(start && !busy, 13) ||
              $past(start && !busy, 15)))
    else $error("result without a matching item");

endmodule

bind aes_block_cipher aes_chk u_chk (.*);
`default_nettype wire
